// File: rtl/media_chunk_deframer_assert.svh
// ----------------------------------------------------------------------------
// media_chunk_deframer_assert.svh
// Assertion macros for the chunk deframer. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef MEDIA_CHUNK_DEFRAMER_ASSERT_SVH
`define MEDIA_CHUNK_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS

// The expression holds at every clock edge out of reset.
`define MCD_ASSERT(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("mcd assertion failed");

// The consequent holds in the cycle after the antecedent.
`define MCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcd assertion failed");

`else

`define MCD_ASSERT(lbl, clk, rst_n, expr)
`define MCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/mcd_pkg.sv
// ----------------------------------------------------------------------------
// mcd_pkg
// Types and constants shared by the media chunk deframer.
// ----------------------------------------------------------------------------
package mcd_pkg;

  // Parser phase, one-hot.
  typedef enum logic [5:0] {
    PH_ID      = 6'b000001,
    PH_SIZE    = 6'b000010,
    PH_TIME    = 6'b000100,
    PH_FLAGS   = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_SKIP    = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_END     = 2'd2,
    KIND_INVALID = 2'd3
  } kind_t;

  // Chunk ids as little-endian words: "00dc" and "01wb".
  localparam logic [31:0] TAG_VIDEO = 32'h6364_3030;
  localparam logic [31:0] TAG_AUDIO = 32'h6277_3130;
  localparam logic [31:0] SIZE_END  = 32'hFFFF_FFFF;
  localparam int unsigned KEY_BIT   = 12;
  localparam logic [31:0] MEDIA_HDR_BYTES = 32'd8;

  // Configuration register map (word index).
  localparam logic REG_STREAM_COUNT = 1'b0;
  localparam logic [1:0] STREAM_COUNT_RST = 2'd2;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic        stream_id;
    logic [31:0] presentation_time;
    logic        key_frame;
    logic [31:0] packet_offset;
    logic        last_of_packet;
  } result_t;

endpackage

// File: rtl/media_chunk_deframer.sv
// ----------------------------------------------------------------------------
// media_chunk_deframer
// Splits the packet area of a container file into chunks and emits payload
// bytes of video and audio chunks with their stream, timestamp and key flag.
// ----------------------------------------------------------------------------
// Results are registered in the output entry, or in the skid entry while
// the output entry waits. One byte is taken per cycle while the skid is free.
// A two-entry output buffer lets input continue while one result is stalled.
// Reset (rst_n low, synchronous) returns the parser to reading a chunk id,
// clears offsets and the halt flag, empties the buffer and sets stream_count
// to 2.
module media_chunk_deframer (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_payload_byte,
  output logic        out_stream_id,
  output logic [31:0] out_presentation_time,
  output logic        out_key_frame,
  output logic [31:0] out_packet_offset,
  output logic        out_last_of_packet,
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

`include "media_chunk_deframer_assert.svh"

  mcd_pkg::phase_t  phase_r, phase_nxt;
  logic [1:0]       field_byte_count_r, field_byte_count_nxt;
  logic [31:0]      assembly_word_r, assembly_word_nxt;
  logic [31:0]      chunk_tag_r, chunk_tag_nxt;
  logic [31:0]      bytes_remaining_r, bytes_remaining_nxt;
  logic [31:0]      held_timestamp_r, held_timestamp_nxt;
  logic             held_key_r, held_key_nxt;
  logic             held_stream_r, held_stream_nxt;
  logic [31:0]      byte_offset_r, byte_offset_nxt;
  logic [31:0]      read_start_offset_r, read_start_offset_nxt;
  logic             halted_r, halted_nxt;
  logic [1:0]       stream_count_r;

  mcd_pkg::result_t out_r, skid_r, res;
  logic             out_valid_r, skid_valid_r;
  logic             produce;
  logic             in_accept, out_take, cfg_write;
  logic [31:0]      word;
  logic [31:0]      next_off;
  logic             media_chunk;
  logic             stream_sel;

  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign cfg_write = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Input is held off only while the skid entry is occupied.
  assign in_stall = skid_valid_r;

  assign word        = {in_data_byte, assembly_word_r[23:0]};
  assign next_off    = byte_offset_r + 32'd1;
  assign media_chunk = (chunk_tag_r == mcd_pkg::TAG_VIDEO) ||
                       (chunk_tag_r == mcd_pkg::TAG_AUDIO);
  assign stream_sel  = (chunk_tag_r == mcd_pkg::TAG_AUDIO);

  always_comb begin
    phase_nxt             = phase_r;
    field_byte_count_nxt  = field_byte_count_r;
    assembly_word_nxt     = assembly_word_r;
    chunk_tag_nxt         = chunk_tag_r;
    bytes_remaining_nxt   = bytes_remaining_r;
    held_timestamp_nxt    = held_timestamp_r;
    held_key_nxt          = held_key_r;
    held_stream_nxt       = held_stream_r;
    byte_offset_nxt       = byte_offset_r;
    read_start_offset_nxt = read_start_offset_r;
    halted_nxt            = halted_r;
    produce               = 1'b0;
    res                   = '0;

    if (in_accept && !halted_r) begin
      byte_offset_nxt = next_off;
      unique case (phase_r) inside
        mcd_pkg::PH_PAYLOAD: begin
          produce                = 1'b1;
          res.kind               = mcd_pkg::KIND_PAYLOAD;
          res.payload_byte       = in_data_byte;
          res.stream_id          = held_stream_r;
          res.presentation_time  = held_timestamp_r;
          res.key_frame          = held_key_r;
          res.packet_offset      = read_start_offset_r;
          res.last_of_packet     = (bytes_remaining_r == 32'd1);
          bytes_remaining_nxt    = bytes_remaining_r - 32'd1;
          if (bytes_remaining_r == 32'd1) begin
            phase_nxt             = mcd_pkg::PH_ID;
            read_start_offset_nxt = next_off;
          end
        end
        mcd_pkg::PH_SKIP: begin
          bytes_remaining_nxt = bytes_remaining_r - 32'd1;
          if (bytes_remaining_r == 32'd1) begin
            phase_nxt = mcd_pkg::PH_ID;
          end
        end
        mcd_pkg::PH_ID, mcd_pkg::PH_SIZE, mcd_pkg::PH_TIME, mcd_pkg::PH_FLAGS: begin
          if (field_byte_count_r != 2'd3) begin
            field_byte_count_nxt = field_byte_count_r + 2'd1;
            assembly_word_nxt[{field_byte_count_r, 3'b000} +: 8] = in_data_byte;
          end else begin
            field_byte_count_nxt = 2'd0;
            assembly_word_nxt    = '0;
            unique case (phase_r)
              mcd_pkg::PH_ID: begin
                chunk_tag_nxt = word;
                phase_nxt     = mcd_pkg::PH_SIZE;
              end
              mcd_pkg::PH_SIZE: begin
                if (word == mcd_pkg::SIZE_END) begin
                  produce    = 1'b1;
                  res.kind   = mcd_pkg::KIND_END;
                  halted_nxt = 1'b1;
                end else if (media_chunk) begin
                  held_stream_nxt = stream_sel;
                  // Too short for timestamp and flags, or a stream the header
                  // never declared.
                  if ((word < mcd_pkg::MEDIA_HDR_BYTES) ||
                      ({1'b0, stream_sel} >= stream_count_r)) begin
                    produce    = 1'b1;
                    res.kind   = mcd_pkg::KIND_INVALID;
                    halted_nxt = 1'b1;
                  end else begin
                    bytes_remaining_nxt = word - mcd_pkg::MEDIA_HDR_BYTES;
                    phase_nxt           = mcd_pkg::PH_TIME;
                  end
                end else if (word == 32'd0) begin
                  phase_nxt = mcd_pkg::PH_ID;
                end else begin
                  bytes_remaining_nxt = word;
                  phase_nxt           = mcd_pkg::PH_SKIP;
                end
              end
              mcd_pkg::PH_TIME: begin
                held_timestamp_nxt = word;
                phase_nxt          = mcd_pkg::PH_FLAGS;
              end
              default: begin
                held_key_nxt = word[mcd_pkg::KEY_BIT];
                if (bytes_remaining_r == 32'd0) begin
                  produce                = 1'b1;
                  res.kind               = mcd_pkg::KIND_EMPTY;
                  res.stream_id          = held_stream_r;
                  res.presentation_time  = held_timestamp_r;
                  res.key_frame          = word[mcd_pkg::KEY_BIT];
                  res.packet_offset      = read_start_offset_r;
                  res.last_of_packet     = 1'b1;
                  phase_nxt              = mcd_pkg::PH_ID;
                  read_start_offset_nxt  = next_off;
                end else begin
                  phase_nxt = mcd_pkg::PH_PAYLOAD;
                end
              end
            endcase
          end
        end
        default: begin
          phase_nxt = mcd_pkg::PH_ID;
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r             <= mcd_pkg::PH_ID;
      field_byte_count_r  <= '0;
      bytes_remaining_r   <= '0;
      byte_offset_r       <= '0;
      read_start_offset_r <= '0;
      halted_r            <= 1'b0;
      stream_count_r      <= mcd_pkg::STREAM_COUNT_RST;
      out_valid_r         <= 1'b0;
      skid_valid_r        <= 1'b0;
    end else begin
      phase_r             <= phase_nxt;
      field_byte_count_r  <= field_byte_count_nxt;
      bytes_remaining_r   <= bytes_remaining_nxt;
      byte_offset_r       <= byte_offset_nxt;
      read_start_offset_r <= read_start_offset_nxt;
      halted_r            <= halted_nxt;
      if (cfg_write && (cfg_paddr[2] == mcd_pkg::REG_STREAM_COUNT)) begin
        stream_count_r <= cfg_pwdata[1:0];
      end
      if (skid_valid_r) begin
        if (out_take) begin
          skid_valid_r <= 1'b0;
        end
      end else if (produce) begin
        if (out_valid_r && !out_take) begin
          skid_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Data registers.
  always_ff @(posedge clk) begin
    assembly_word_r  <= assembly_word_nxt;
    chunk_tag_r      <= chunk_tag_nxt;
    held_timestamp_r <= held_timestamp_nxt;
    held_key_r       <= held_key_nxt;
    held_stream_r    <= held_stream_nxt;
    if (skid_valid_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (produce) begin
      if (out_valid_r && !out_take) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_kind              = out_r.kind;
  assign out_payload_byte      = out_r.payload_byte;
  assign out_stream_id         = out_r.stream_id;
  assign out_presentation_time = out_r.presentation_time;
  assign out_key_frame         = out_r.key_frame;
  assign out_packet_offset     = out_r.packet_offset;
  assign out_last_of_packet    = out_r.last_of_packet;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == mcd_pkg::REG_STREAM_COUNT) ?
                      {30'd0, stream_count_r} : 32'd0;

  // The skid entry is only ever filled behind a waiting output entry.
  `MCD_ASSERT(a_skid_behind_out, clk, rst_n, !skid_valid_r || out_valid_r)
  // Once stopped, no byte yields a result.
  `MCD_ASSERT(a_halted_silent, clk, rst_n, !(halted_r && produce))
  // End and invalid results stop the parser.
  `MCD_ASSERT_NEXT(a_halt_after_final, clk, rst_n,
                   produce && ((res.kind == mcd_pkg::KIND_END) ||
                               (res.kind == mcd_pkg::KIND_INVALID)),
                   halted_r)
  // Only payload results carry a byte.
  `MCD_ASSERT(a_payload_zero, clk, rst_n,
              !out_valid_r || (out_r.kind == mcd_pkg::KIND_PAYLOAD) ||
              (out_r.payload_byte == 8'd0))
  // The field byte counter only moves while assembling a header word.
  `MCD_ASSERT(a_count_in_field, clk, rst_n,
              (field_byte_count_r == 2'd0) || (phase_r == mcd_pkg::PH_ID) ||
              (phase_r == mcd_pkg::PH_SIZE) || (phase_r == mcd_pkg::PH_TIME) ||
              (phase_r == mcd_pkg::PH_FLAGS))

endmodule
